// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/llsel_pkg.sv =====
package llsel_pkg;

    // Input item: one list byte or the end marker
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] expr_offset;
        logic [15:0] expr_length;
        logic [63:0] range_start;
        logic [63:0] range_end;
    } t_out_item;

    // Configuration register values
    typedef struct packed {
        logic [63:0] pc;
        logic        wide_addresses;
        logic [63:0] initial_base;
    } t_cfg;

    // Result hand-off from parser to output register
    typedef struct packed {
        logic      push;
        t_out_item item;
    } t_result_push;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] ST_FOUND      = 2'd0;
    localparam logic [1:0] ST_NO_ENTRY   = 2'd1;
    localparam logic [1:0] ST_EMPTY_EXPR = 2'd2;
    localparam logic [1:0] ST_NO_DATA    = 2'd3;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd2;

    localparam logic [63:0] ALL_ONES_NARROW = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES_WIDE   = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [4:0] ADDR_BYTES_NARROW = 5'd4;
    localparam logic [4:0] ADDR_BYTES_WIDE   = 5'd8;

endpackage

// ===== rtl/core/llsel_cfg.sv =====
module llsel_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [llsel_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [63:0]                           i_cfg_data,
    output llsel_pkg::t_cfg                       o_cfg
);
    import llsel_pkg::*;

    t_cfg r_cfg;

    // Register file, write only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pc             <= '0;
            r_cfg.wide_addresses <= 1'b1;
            r_cfg.initial_base   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PC:   r_cfg.pc             <= i_cfg_data;
                REG_WIDE: r_cfg.wide_addresses <= i_cfg_data[0];
                REG_BASE: r_cfg.initial_base   <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/llsel_parser.sv =====
module llsel_parser #(
    parameter longint unsigned MAX_LIST_BYTES = 65536
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  llsel_pkg::t_in_item    i_item,
    input  llsel_pkg::t_cfg        i_cfg,
    output llsel_pkg::t_result_push o_result
);
    import llsel_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_LIST_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LIST_BYTES);

    // Parse state
    logic [4:0]       r_hdr_count, n_hdr_count;
    logic [63:0]      r_start,     n_start;
    logic [63:0]      r_end,       n_end;
    logic [63:0]      r_base,      n_base;
    logic [15:0]      r_len,       n_len;
    logic [15:0]      r_left,      n_left;
    logic [POS_W-1:0] r_pos,       n_pos;
    logic             r_stopped,   n_stopped;
    logic             r_found,     n_found;
    logic             r_pending,   n_pending;
    logic [15:0]      r_m_offset,  n_m_offset;
    logic [15:0]      r_m_len,     n_m_len;
    logic [63:0]      r_m_start,   n_m_start;
    logic [63:0]      r_m_end,     n_m_end;

    logic [4:0]  addr_bytes;
    logic [63:0] all_ones;
    logic [4:0]  end_idx;
    logic [63:0] start_or;
    logic [63:0] end_or;
    logic [15:0] full_len;
    logic [63:0] lo_sum;
    logic [63:0] hi_sum;
    logic        covers;
    t_result_push result;

    assign addr_bytes = i_cfg.wide_addresses ? ADDR_BYTES_WIDE : ADDR_BYTES_NARROW;
    assign all_ones   = i_cfg.wide_addresses ? ALL_ONES_WIDE : ALL_ONES_NARROW;
    assign end_idx    = r_hdr_count - addr_bytes;

    // Byte merged into the address fields at the current header position
    assign start_or = r_start | (64'(i_item.data_byte) << {r_hdr_count[2:0], 3'b000});
    assign end_or   = r_end   | (64'(i_item.data_byte) << {end_idx[2:0], 3'b000});
    assign full_len = {i_item.data_byte, r_len[7:0]};

    // Range check of the finished header
    assign lo_sum = r_base + r_start;
    assign hi_sum = r_base + r_end;
    assign covers = (lo_sum <= i_cfg.pc) && (i_cfg.pc < hi_sum);

    always_comb begin
        n_hdr_count = r_hdr_count;
        n_start     = r_start;
        n_end       = r_end;
        n_base      = r_base;
        n_len       = r_len;
        n_left      = r_left;
        n_pos       = r_pos;
        n_stopped   = r_stopped;
        n_found     = r_found;
        n_pending   = r_pending;
        n_m_offset  = r_m_offset;
        n_m_len     = r_m_len;
        n_m_start   = r_m_start;
        n_m_end     = r_m_end;
        result      = '0;

        if (i_accept) begin
            if (i_item.kind == KIND_END) begin
                // Report and start a fresh list
                result.push = 1'b1;
                if (r_pos == '0) begin
                    result.item.status = ST_NO_DATA;
                end else if (!r_found) begin
                    result.item.status = ST_NO_ENTRY;
                end else begin
                    result.item.status      = (r_m_len == '0) ? ST_EMPTY_EXPR : ST_FOUND;
                    result.item.expr_offset = r_m_offset;
                    result.item.expr_length = r_m_len;
                    result.item.range_start = r_m_start;
                    result.item.range_end   = r_m_end;
                end
                n_hdr_count = '0;
                n_start     = '0;
                n_end       = '0;
                n_base      = i_cfg.initial_base;
                n_len       = '0;
                n_left      = '0;
                n_pos       = '0;
                n_stopped   = 1'b0;
                n_found     = 1'b0;
                n_pending   = 1'b0;
                n_m_offset  = '0;
                n_m_len     = '0;
                n_m_start   = '0;
                n_m_end     = '0;
            end else if (r_pos < POS_LIMIT) begin
                n_pos = r_pos + 1'b1;
                if (!r_stopped) begin
                    if (r_left != '0) begin
                        // Skip expression byte
                        n_left = r_left - 1'b1;
                        if (r_left == 16'd1 && r_pending) begin
                            n_pending = 1'b0;
                            n_found   = 1'b1;
                            n_stopped = 1'b1;
                        end
                    end else if (r_hdr_count < addr_bytes) begin
                        n_start     = start_or;
                        n_hdr_count = r_hdr_count + 1'b1;
                    end else if (r_hdr_count < {addr_bytes[3:0], 1'b0}) begin
                        n_end       = end_or;
                        n_hdr_count = r_hdr_count + 1'b1;
                        if (r_hdr_count == {addr_bytes[3:0], 1'b0} - 5'd1) begin
                            if (r_start == '0 && end_or == '0) begin
                                // end of list entry
                                n_stopped = 1'b1;
                            end else if (r_start == all_ones) begin
                                // base address selection entry
                                n_base      = end_or;
                                n_hdr_count = '0;
                                n_start     = '0;
                                n_end       = '0;
                            end
                        end
                    end else if (r_hdr_count == {addr_bytes[3:0], 1'b0}) begin
                        n_len       = {8'd0, i_item.data_byte};
                        n_hdr_count = r_hdr_count + 1'b1;
                    end else begin
                        // Length high byte: header complete
                        n_len = full_len;
                        if (covers) begin
                            n_pending  = 1'b1;
                            n_m_offset = 16'(n_pos);
                            n_m_len    = full_len;
                            n_m_start  = lo_sum;
                            n_m_end    = hi_sum;
                        end
                        n_hdr_count = '0;
                        n_start     = '0;
                        n_end       = '0;
                        n_left      = full_len;
                        if (full_len == '0 && (covers || r_pending)) begin
                            n_pending = 1'b0;
                            n_found   = 1'b1;
                            n_stopped = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_count <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_base      <= '0;
            r_len       <= '0;
            r_left      <= '0;
            r_pos       <= '0;
            r_stopped   <= 1'b0;
            r_found     <= 1'b0;
            r_pending   <= 1'b0;
            r_m_offset  <= '0;
            r_m_len     <= '0;
            r_m_start   <= '0;
            r_m_end     <= '0;
        end else begin
            r_hdr_count <= n_hdr_count;
            r_start     <= n_start;
            r_end       <= n_end;
            r_base      <= n_base;
            r_len       <= n_len;
            r_left      <= n_left;
            r_pos       <= n_pos;
            r_stopped   <= n_stopped;
            r_found     <= n_found;
            r_pending   <= n_pending;
            r_m_offset  <= n_m_offset;
            r_m_len     <= n_m_len;
            r_m_start   <= n_m_start;
            r_m_end     <= n_m_end;
        end
    end

    assign o_result = result;

endmodule

// ===== rtl/core/llsel_out_reg.sv =====
module llsel_out_reg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  llsel_pkg::t_result_push i_result,
    output logic                    o_space,
    output logic                    o_valid,
    input  logic                    i_ready,
    output llsel_pkg::t_out_item    o_item
);
    import llsel_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // Free now, or freed by the transaction at this edge
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.push) begin
            r_item <= i_result.item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/core/location_list_entry_selector.sv =====
// Location list entry selector: takes a DWARF 4 location list one byte per
// transaction, then an end marker, and returns one result for the end marker
// with the status (found, no entry, empty expression, no data) and, when an
// entry covering pc was selected, its expression offset, length and range.
// The parse state registers take one step per transaction, so a byte or an
// end marker can be accepted in every cycle while the output register has
// space. The result of an end marker is offered in the cycle after it is
// accepted. An input transaction of either kind waits only while a previous
// result sits in the output register and is not being taken in the same
// cycle. Bytes beyond MAX_LIST_BYTES are dropped. Configuration is written
// through a plain write port; the user must do this only while idle, and the block does not enforce it.
module location_list_entry_selector #(
    parameter longint unsigned MAX_LIST_BYTES = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [llsel_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  llsel_pkg::t_in_item             i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output llsel_pkg::t_out_item            o_out_data
);
    import llsel_pkg::*;

`include "assert_macros.svh"

    t_cfg         cfg;
    t_result_push result;
    logic         out_space;
    logic         in_accept;

    // Assertion terms
    logic         end_accept;
    logic         out_stalled;
    logic         sel_report;
    logic         nosel_report;
    logic         covers_pc;
    logic         nosel_zero;

    assign o_in_ready = out_space;
    assign in_accept  = i_in_valid && out_space;

    llsel_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    llsel_parser #(
        .MAX_LIST_BYTES (MAX_LIST_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    llsel_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .o_space  (out_space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_item   (o_out_data)
    );

    assign end_accept   = in_accept && i_in_data.kind == KIND_END;
    assign out_stalled  = o_out_valid && !i_out_ready;
    assign sel_report   = o_out_valid && (o_out_data.status == ST_FOUND
                                          || o_out_data.status == ST_EMPTY_EXPR);
    assign nosel_report = o_out_valid && (o_out_data.status == ST_NO_ENTRY
                                          || o_out_data.status == ST_NO_DATA);
    assign covers_pc    = o_out_data.range_start <= cfg.pc && cfg.pc < o_out_data.range_end;
    assign nosel_zero   = o_out_data.expr_length == '0 && o_out_data.range_end == '0;

    // End marker transaction always yields a result next cycle
    `ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, end_accept, o_out_valid)

    // A held result is never overwritten
    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, out_stalled, !result.push)

    // Selected range covers pc
    `ASSERT_IMPLIES(a_range_covers_pc, i_clk, i_rst_n, sel_report, covers_pc)

    // No selection carries zero fields
    `ASSERT_IMPLIES(a_no_sel_zero, i_clk, i_rst_n, nosel_report, nosel_zero)

endmodule
